/* design/ppe_pkg.sv */
// shared types, constants and helper functions for the particle pool engine
package ppe_pkg;

    // pool geometry
    localparam int POOL_SIZE = 1024;
    localparam int SLOT_W    = $clog2(POOL_SIZE);

    // fixed-point constants
    localparam logic [18:0] TWO_PI_Q16  = 19'd411775;
    localparam logic [25:0] TURN_RECIP  = 26'd42949673;   // ceil(2^32 / 100)
    localparam logic [24:0] TURN_BIAS   = 25'd50;
    localparam logic [17:0] FRAC_ONE    = 18'd65536;
    localparam int          DIV_STEPS   = 17;
    localparam int          DIV_CNT_W   = $clog2(DIV_STEPS);

    // operation codes
    typedef enum logic [1:0] {
        OP_EMIT  = 2'd0,
        OP_TICK  = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_VEL_SPREAD_X = 3'd0,
        REG_VEL_SPREAD_Y = 3'd1,
        REG_SIZE_SPREAD  = 3'd2,
        REG_START_SIZE   = 3'd3,
        REG_FINAL_SIZE   = 3'd4,
        REG_LIFETIME     = 3'd5,
        REG_START_COLOR  = 3'd6,
        REG_FINAL_COLOR  = 3'd7
    } reg_idx_t;

    // main sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EMIT_WR,
        ST_TICK_RUN,
        ST_TICK_DRAIN,
        ST_Q_READ,
        ST_Q_DIV,
        ST_Q_MUL1,
        ST_Q_MUL2,
        ST_Q_OUT
    } state_t;

    // one pool slot as held in the slot memory
    typedef struct packed {
        logic               active;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] angle;
        logic signed [31:0] life_left;
        logic        [23:0] life_total;
        logic signed [31:0] size_begin;
    } entry_t;

    // saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // round half up, then drop 16 fraction bits
    function automatic logic signed [63:0] round_sh16(input logic signed [63:0] v);
        logic signed [63:0] w;
        w = v + 64'sd32768;
        return w >>> 16;
    endfunction

    // clamp to one colour byte
    function automatic logic [7:0] clamp_byte(input logic signed [63:0] v);
        logic [7:0] r;
        if (v < 64'sd0)
            r = 8'd0;
        else if (v > 64'sd255)
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

/* design/ppe_divider.sv */
// restoring divider for the life fraction, one quotient bit per cycle
module ppe_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] life_left,
    input  logic        [23:0] life_total,
    output logic               done,
    output logic signed [17:0] frac
);
    import ppe_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [23:0]          rem_reg;
    logic [16:0]          q_reg;
    logic                 lsb_reg;
    logic                 neg_reg;
    logic                 sat_reg;
    logic                 zero_reg;
    logic [23:0]          div_reg;
    logic signed [17:0]   frac_reg;

    logic [31:0]        mag;
    logic               in_bit;
    logic [24:0]        trial;
    logic               q_bit;
    logic [23:0]        rem_next;
    logic [16:0]        q_next;
    logic [17:0]        mag_q;
    logic signed [17:0] frac_next;

    // magnitude of the dividend
    assign mag = life_left[31] ? 32'(-33'(life_left)) : life_left[31:0];

    // one restoring step
    always_comb
    begin
        in_bit   = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) ? lsb_reg : 1'b0;
        trial    = {rem_reg, in_bit};
        q_bit    = (trial >= {1'b0, div_reg});
        rem_next = q_bit ? 24'(trial - {1'b0, div_reg}) : trial[23:0];
        q_next   = {q_reg[15:0], q_bit};
        if (zero_reg)
            mag_q = 18'd0;
        else if (sat_reg || ({1'b0, q_next} > FRAC_ONE))
            mag_q = FRAC_ONE;
        else
            mag_q = {1'b0, q_next};
        frac_next = neg_reg ? -$signed(mag_q) : $signed(mag_q);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= mag[24:1];
            lsb_reg  <= mag[0];
            q_reg    <= '0;
            div_reg  <= life_total;
            neg_reg  <= life_left[31];
            zero_reg <= (life_total == 24'd0);
            sat_reg  <= ({1'b0, mag} >= {8'd0, life_total, 1'b0});
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            if (cnt_reg == '0)
                frac_reg <= frac_next;
        end
    end

    assign done = done_reg;
    assign frac = frac_reg;

endmodule

/* design/particle_pool_engine.sv */
// top level: particle pool sequencer, slot memory and query datapath
//
//  channel | signals                         | direction | transfer when
//  input   | in_valid, in_stall, op..rand_size | in      | in_valid & !in_stall
//  result  | out_valid, out_stall, alive..     | out     | out_valid & !out_stall
//  config  | cfg_we, cfg_index, cfg_data     | in        | cfg_we
//
// emit writes one slot in ST_EMIT_WR; a query of an active slot goes through
// ST_Q_READ, the 17-step life divider, ST_Q_MUL1, ST_Q_MUL2 and ST_Q_OUT;
// tick reads one slot per cycle. a clearing pass after reset walks all slots with
// in_stall high. a finished query result waits in the output register while the
// next item is taken; a query only stalls if that register is still full.
module particle_pool_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                op,
    input  logic [9:0]                slot,
    input  logic [23:0]               delta_time,
    input  logic signed [31:0]        birth_x,
    input  logic signed [31:0]        birth_y,
    input  logic signed [31:0]        base_vel_x,
    input  logic signed [31:0]        base_vel_y,
    input  logic [15:0]               rand_angle,
    input  logic [15:0]               rand_vx,
    input  logic [15:0]               rand_vy,
    input  logic [15:0]               rand_size,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      alive,
    output logic signed [31:0]        out_x,
    output logic signed [31:0]        out_y,
    output logic signed [31:0]        out_angle,
    output logic signed [31:0]        out_size,
    output logic [31:0]               out_color,
    output logic signed [17:0]        life_fraction,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [31:0]               cfg_data
);
    import ppe_pkg::*;

    // configuration registers
    logic [30:0] vel_spread_x_reg;
    logic [30:0] vel_spread_y_reg;
    logic [30:0] size_spread_reg;
    logic [30:0] start_size_reg;
    logic [30:0] final_size_reg;
    logic [23:0] lifetime_reg;
    logic [31:0] start_color_reg;
    logic [31:0] final_color_reg;

    // sequencer
    state_t              state_reg;
    state_t              state_next;
    logic [SLOT_W-1:0]   idx_reg;
    logic [SLOT_W-1:0]   next_slot_reg;
    logic                in_xfer;
    logic                out_xfer;
    logic                out_free;

    // slot memory
    entry_t              mem [POOL_SIZE];
    entry_t              rd_q;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    entry_t              mem_wdata;
    logic                mem_re;
    logic [SLOT_W-1:0]   mem_raddr;

    // emit operands
    logic signed [31:0]  e_pos_x_reg;
    logic signed [31:0]  e_pos_y_reg;
    logic signed [31:0]  e_base_x_reg;
    logic signed [31:0]  e_base_y_reg;
    logic [34:0]         e_angle_prod_reg;
    logic signed [49:0]  e_vx_prod_reg;
    logic signed [49:0]  e_vy_prod_reg;
    logic signed [49:0]  e_size_prod_reg;
    logic signed [17:0]  c_vx;
    logic signed [17:0]  c_vy;
    logic signed [17:0]  c_size;
    entry_t              emit_entry;

    // tick pipeline
    logic [23:0]         dt_reg;
    logic [18:0]         turn_reg;
    logic [50:0]         turn_prod;
    logic                v1_reg;
    logic [SLOT_W-1:0]   a1_reg;
    logic                v2_reg;
    logic [SLOT_W-1:0]   a2_reg;
    entry_t              e2_reg;
    logic signed [56:0]  px_prod_reg;
    logic signed [56:0]  py_prod_reg;
    entry_t              tick_entry;

    // query datapath
    entry_t              q_entry_reg;
    logic                q_dead_reg;
    logic                div_start;
    logic                div_done;
    logic signed [17:0]  frac;
    logic signed [50:0]  size_prod_reg;
    logic signed [26:0]  col_prod_reg [3];
    logic signed [27:0]  a_q16_reg;
    logic signed [45:0]  alpha_prod_reg;
    logic signed [31:0]  size_res_reg;
    logic [23:0]         rgb_res_reg;

    // output register
    logic                out_valid_reg;
    logic                alive_reg;
    logic signed [31:0]  out_x_reg;
    logic signed [31:0]  out_y_reg;
    logic signed [31:0]  out_angle_reg;
    logic signed [31:0]  out_size_reg;
    logic [31:0]         out_color_reg;
    logic signed [17:0]  life_fraction_reg;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // life fraction divider
    ppe_divider u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .life_left  (rd_q.life_left),
        .life_total (rd_q.life_total),
        .done       (div_done),
        .frac       (frac)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_spread_x_reg <= '0;
            vel_spread_y_reg <= '0;
            size_spread_reg  <= '0;
            start_size_reg   <= 31'd65536;
            final_size_reg   <= '0;
            lifetime_reg     <= 24'd65536;
            start_color_reg  <= 32'hFFFFFFFF;
            final_color_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VEL_SPREAD_X: vel_spread_x_reg <= cfg_data[30:0];
                REG_VEL_SPREAD_Y: vel_spread_y_reg <= cfg_data[30:0];
                REG_SIZE_SPREAD:  size_spread_reg  <= cfg_data[30:0];
                REG_START_SIZE:   start_size_reg   <= cfg_data[30:0];
                REG_FINAL_SIZE:   final_size_reg   <= cfg_data[30:0];
                REG_LIFETIME:     lifetime_reg     <= cfg_data[23:0];
                REG_START_COLOR:  start_color_reg  <= cfg_data;
                REG_FINAL_COLOR:  final_color_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (idx_reg == SLOT_W'(POOL_SIZE - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_xfer)
                begin
                    case (op)
                        OP_EMIT:  state_next = ST_EMIT_WR;
                        OP_TICK:  state_next = ST_TICK_RUN;
                        OP_QUERY: state_next = ST_Q_READ;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            ST_EMIT_WR:
                state_next = ST_IDLE;
            ST_TICK_RUN:
                if (idx_reg == SLOT_W'(POOL_SIZE - 1))
                    state_next = ST_TICK_DRAIN;
            ST_TICK_DRAIN:
                if (!v1_reg && !v2_reg)
                    state_next = ST_IDLE;
            ST_Q_READ:
                state_next = rd_q.active ? ST_Q_DIV : ST_Q_OUT;
            ST_Q_DIV:
                if (div_done)
                    state_next = ST_Q_MUL1;
            ST_Q_MUL1:
                state_next = ST_Q_MUL2;
            ST_Q_MUL2:
                state_next = ST_Q_OUT;
            ST_Q_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // memory and unit control
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        mem_we    = 1'b0;
        mem_waddr = a2_reg;
        mem_wdata = tick_entry;
        mem_re    = 1'b0;
        mem_raddr = idx_reg;
        div_start = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                mem_re    = in_xfer && (op == OP_QUERY);
                mem_raddr = slot[SLOT_W-1:0];
            end
            ST_EMIT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = next_slot_reg;
                mem_wdata = emit_entry;
            end
            ST_TICK_RUN:
            begin
                mem_re = 1'b1;
                mem_we = v2_reg && e2_reg.active;
            end
            ST_TICK_DRAIN:
                mem_we = v2_reg && e2_reg.active;
            ST_Q_READ:
                div_start = rd_q.active;
            default: ;
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            next_slot_reg <= SLOT_W'(POOL_SIZE - 1);
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == ST_TICK_RUN);
            v2_reg    <= v1_reg;
            if (state_reg == ST_CLEAR || state_reg == ST_TICK_RUN)
            begin
                if (idx_reg == SLOT_W'(POOL_SIZE - 1))
                    idx_reg <= '0;
                else
                    idx_reg <= idx_reg + 1'b1;
            end
            if (state_reg == ST_EMIT_WR)
            begin
                if (next_slot_reg == '0)
                    next_slot_reg <= SLOT_W'(POOL_SIZE - 1);
                else
                    next_slot_reg <= next_slot_reg - 1'b1;
            end
        end
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_q <= mem[mem_raddr];
    end

    // emit: centred random terms and tick turn product
    always_comb
    begin
        c_vx      = $signed({2'b00, rand_vx}) - 18'sd32768;
        c_vy      = $signed({2'b00, rand_vy}) - 18'sd32768;
        c_size    = $signed({2'b00, rand_size}) - 18'sd32768;
        turn_prod = 51'((25'(delta_time) + TURN_BIAS) * TURN_RECIP);
    end

    // operands captured at the input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            e_pos_x_reg      <= birth_x;
            e_pos_y_reg      <= birth_y;
            e_base_x_reg     <= base_vel_x;
            e_base_y_reg     <= base_vel_y;
            e_angle_prod_reg <= 35'(rand_angle * TWO_PI_Q16);
            e_vx_prod_reg    <= $signed({1'b0, vel_spread_x_reg}) * c_vx;
            e_vy_prod_reg    <= $signed({1'b0, vel_spread_y_reg}) * c_vy;
            e_size_prod_reg  <= $signed({1'b0, size_spread_reg}) * c_size;
            dt_reg           <= delta_time;
            turn_reg         <= turn_prod[50:32];
        end
    end

    // emitted slot contents
    always_comb
    begin
        emit_entry.active     = 1'b1;
        emit_entry.pos_x      = e_pos_x_reg;
        emit_entry.pos_y      = e_pos_y_reg;
        emit_entry.angle      = 32'(round_sh16(64'($signed({1'b0, e_angle_prod_reg}))));
        emit_entry.vel_x      = sat32(64'(e_base_x_reg) + round_sh16(64'(e_vx_prod_reg)));
        emit_entry.vel_y      = sat32(64'(e_base_y_reg) + round_sh16(64'(e_vy_prod_reg)));
        emit_entry.life_total = lifetime_reg;
        emit_entry.life_left  = $signed({8'd0, lifetime_reg});
        emit_entry.size_begin = sat32(64'($signed({1'b0, start_size_reg}))
                                + round_sh16(64'(e_size_prod_reg)));
    end

    // tick pipeline: products of the slot just read
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            a2_reg      <= a1_reg;
            e2_reg      <= rd_q;
            px_prod_reg <= rd_q.vel_x * $signed({1'b0, dt_reg});
            py_prod_reg <= rd_q.vel_y * $signed({1'b0, dt_reg});
        end
        a1_reg <= idx_reg;
    end

    // tick pipeline: updated slot contents
    always_comb
    begin
        tick_entry = e2_reg;
        if (e2_reg.life_left <= 32'sd0)
            tick_entry.active = 1'b0;
        else
        begin
            tick_entry.life_left = sat32(64'(e2_reg.life_left) - 64'($signed({1'b0, dt_reg})));
            tick_entry.pos_x = sat32(64'(e2_reg.pos_x) + round_sh16(64'(px_prod_reg)));
            tick_entry.pos_y = sat32(64'(e2_reg.pos_y) + round_sh16(64'(py_prod_reg)));
            tick_entry.angle = sat32(64'(e2_reg.angle) + 64'($signed({1'b0, turn_reg})));
        end
    end

    // query datapath
    always_ff @(posedge clk)
    begin
        logic signed [32:0] size_diff;
        logic signed [8:0]  cdiff;
        if (state_reg == ST_Q_READ)
        begin
            q_entry_reg <= rd_q;
            q_dead_reg  <= !rd_q.active;
        end
        if (state_reg == ST_Q_MUL1)
        begin
            size_diff     = 33'(q_entry_reg.size_begin) - $signed({2'b00, final_size_reg});
            size_prod_reg <= size_diff * frac;
            for (int k = 0; k < 3; k++)
            begin
                cdiff = $signed({1'b0, start_color_reg[8*k+8 +: 8]})
                        - $signed({1'b0, final_color_reg[8*k+8 +: 8]});
                col_prod_reg[k] <= cdiff * frac;
            end
            cdiff     = $signed({1'b0, start_color_reg[7:0]})
                        - $signed({1'b0, final_color_reg[7:0]});
            a_q16_reg <= $signed({4'd0, final_color_reg[7:0], 16'd0}) + 28'(cdiff * frac);
        end
        if (state_reg == ST_Q_MUL2)
        begin
            alpha_prod_reg <= a_q16_reg * frac;
            size_res_reg   <= sat32(round_sh16(64'($signed({1'b0, final_size_reg, 16'd0}))
                                               + 64'(size_prod_reg)));
            for (int k = 0; k < 3; k++)
                rgb_res_reg[8*k +: 8] <= clamp_byte(round_sh16(
                    64'($signed({1'b0, final_color_reg[8*k+8 +: 8], 16'd0}))
                    + 64'(col_prod_reg[k])));
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_Q_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (out_xfer)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_Q_OUT && out_free)
        begin
            if (q_dead_reg)
            begin
                alive_reg         <= 1'b0;
                out_x_reg         <= '0;
                out_y_reg         <= '0;
                out_angle_reg     <= '0;
                out_size_reg      <= '0;
                out_color_reg     <= '0;
                life_fraction_reg <= '0;
            end
            else
            begin
                alive_reg         <= 1'b1;
                out_x_reg         <= q_entry_reg.pos_x;
                out_y_reg         <= q_entry_reg.pos_y;
                out_angle_reg     <= q_entry_reg.angle;
                out_size_reg      <= size_res_reg;
                out_color_reg     <= {rgb_res_reg, clamp_byte((64'(alpha_prod_reg)
                                      + 64'sd2147483648) >>> 32)};
                life_fraction_reg <= frac;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign alive         = alive_reg;
    assign out_x         = out_x_reg;
    assign out_y         = out_y_reg;
    assign out_angle     = out_angle_reg;
    assign out_size      = out_size_reg;
    assign out_color     = out_color_reg;
    assign life_fraction = life_fraction_reg;

endmodule
